FILE: rtl/core/gmd_pkg.sv
// ----------------------------------------------------------------------------
// gmd_pkg
// Shared types and codes of the grid maze depth-first path core.
// ----------------------------------------------------------------------------
package gmd_pkg;

   // command codes
   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_SEARCH  = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;
   localparam logic [1:0] ACT_RESTART = 2'd3;

   // cell kinds
   localparam logic [1:0] KIND_FLOOR = 2'd0;
   localparam logic [1:0] KIND_WALL  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   // move codes: right, left, down, up; DIR_DONE marks an exhausted cell
   localparam int unsigned DIR_W = 3;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
   localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

   // register indexes
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   localparam int unsigned DIM_W = 7;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] cell_kind;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [11:0] path_length;
      logic [1:0]  step_dir;
      logic        last;
      logic        error;
   } rsp_type;

endpackage

FILE: rtl/core/gmd_ram.sv
// ----------------------------------------------------------------------------
// gmd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gmd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/grid_maze_dfs_path_core.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_core
// Maze loader and depth-first path finder with path readback.
// ----------------------------------------------------------------------------
//  channel | ports                                 | transfer when
//  --------+---------------------------------------+-----------------------
//  command | start, busy, req_data                 | start && !busy
//  result  | rsp_valid, rsp_data                   | rsp_valid (1 cycle)
//  config  | csr_valid, csr_ready, csr_index/data  | csr_valid && csr_ready
//
// Cycles: load, restart and failed reads answer the cycle after the transfer;
// the next command may follow at once. A good path read passes through S_PATH.
// A search clears the visited map in S_CLEAR and inits in S_INIT; each
// direction tried or pop then runs S_READ and S_EVAL, plus S_CHECK when the
// neighbor is in the grid (wall/visited check); the result strobes the cycle
// after the end. Reset clears control state only; results cannot be stalled.
module grid_maze_dfs_path_core #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  gmd_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output gmd_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [gmd_pkg::DIM_W-1:0] csr_data
);

   localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
   localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;   // cell index
   localparam int unsigned CW    = $clog2(CELLS + 1);                 // cell count
   localparam int unsigned RB    = $clog2(MAX_ROWS + 1);
   localparam int unsigned CB    = $clog2(MAX_COLS + 1);
   localparam int unsigned RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned SW    = AW + RIW + CIW;                    // stack entry
   localparam int unsigned DW    = gmd_pkg::DIR_W;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_PATH  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [6:0]          rows_cfg_ff, rows_cfg_in;
   logic [6:0]          cols_cfg_ff, cols_cfg_in;
   logic [CW-1:0]       load_pos_ff, load_pos_in;
   logic [CW-1:0]       start_ff, start_in;
   logic                start_ok_ff, start_ok_in;
   logic [CW-1:0]       end_ff, end_in;
   logic                end_ok_ff, end_ok_in;
   logic                found_ff, found_in;
   logic [CW-1:0]       plen_ff, plen_in;
   logic [CW-1:0]       rpos_ff, rpos_in;
   logic [CW-1:0]       top_ff, top_in;
   logic [CW-1:0]       clr_ff, clr_in;
   logic [RIW-1:0]      cr_ff, cr_in;
   logic [CIW-1:0]      cc_ff, cc_in;
   logic [RIW-1:0]      sr_ff, sr_in;
   logic [CIW-1:0]      sc_ff, sc_in;
   logic [RB-1:0]       rows_s_ff, rows_s_in;
   logic [CB-1:0]       cols_s_ff, cols_s_in;
   logic [CW-1:0]       cells_s_ff, cells_s_in;
   logic [AW-1:0]       nb_ff, nb_in;
   logic [RIW-1:0]      nr_ff, nr_in;
   logic [CIW-1:0]      nc_ff, nc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gmd_pkg::rsp_type    rsp_ff, rsp_in;

   logic [RB-1:0]       rows_eff;
   logic [CB-1:0]       cols_eff;
   logic [CW-1:0]       cells_now;
   logic [CW-1:0]       top_m1;
   logic                accept;

   // RAM controls
   logic                wall_we, wall_wd, wall_rd;
   logic [AW-1:0]       wall_wa;
   logic                vis_we, vis_wd, vis_rd;
   logic [AW-1:0]       vis_wa;
   logic                stk_we;
   logic [AW-1:0]       stk_wa, stk_ra;
   logic [SW-1:0]       stk_wd, stk_rd;
   logic                dir_we;
   logic [AW-1:0]       dir_wa, dir_ra;
   logic [DW-1:0]       dir_wd, dir_rd;

   logic [AW-1:0]       cur_cell;
   logic [RIW-1:0]      cur_r;
   logic [CIW-1:0]      cur_c;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // effective dims: zero reads as one, clamp at the maximum
   always_comb begin
      if (rows_cfg_ff == 7'd0) begin
         rows_eff = RB'(1);
      end else if (int'(rows_cfg_ff) > int'(MAX_ROWS)) begin
         rows_eff = RB'(MAX_ROWS);
      end else begin
         rows_eff = RB'(rows_cfg_ff);
      end
      if (cols_cfg_ff == 7'd0) begin
         cols_eff = CB'(1);
      end else if (int'(cols_cfg_ff) > int'(MAX_COLS)) begin
         cols_eff = CB'(MAX_COLS);
      end else begin
         cols_eff = CB'(cols_cfg_ff);
      end
   end

   assign cells_now = CW'(rows_eff) * CW'(cols_eff);
   assign top_m1    = top_ff - CW'(1);

   assign cur_cell = stk_rd[SW-1 -: AW];
   assign cur_r    = stk_rd[CIW +: RIW];
   assign cur_c    = stk_rd[CIW-1:0];

   always_comb begin
      state_in     = state_ff;
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      load_pos_in  = load_pos_ff;
      start_in     = start_ff;
      start_ok_in  = start_ok_ff;
      end_in       = end_ff;
      end_ok_in    = end_ok_ff;
      found_in     = found_ff;
      plen_in      = plen_ff;
      rpos_in      = rpos_ff;
      top_in       = top_ff;
      clr_in       = clr_ff;
      cr_in        = cr_ff;
      cc_in        = cc_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      rows_s_in    = rows_s_ff;
      cols_s_in    = cols_s_ff;
      cells_s_in   = cells_s_ff;
      nb_in        = nb_ff;
      nr_in        = nr_ff;
      nc_in        = nc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      wall_we = 1'b0;
      wall_wa = load_pos_ff[AW-1:0];
      wall_wd = (req_data.cell_kind == gmd_pkg::KIND_WALL);
      vis_we  = 1'b0;
      vis_wa  = clr_ff[AW-1:0];
      vis_wd  = 1'b0;
      stk_we  = 1'b0;
      stk_wa  = top_ff[AW-1:0];
      stk_wd  = {nb_ff, nr_ff, nc_ff};
      stk_ra  = top_m1[AW-1:0];
      dir_we  = 1'b0;
      dir_wa  = top_ff[AW-1:0];
      dir_wd  = gmd_pkg::DIR_RIGHT;
      dir_ra  = (state_ff == S_IDLE) ? rpos_ff[AW-1:0] : top_m1[AW-1:0];

      if (csr_valid) begin
         if (csr_index == gmd_pkg::CSR_ROWS) begin
            rows_cfg_in = csr_data;
         end else begin
            cols_cfg_in = csr_data;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.found       = found_ff;
               rsp_in.path_length = 12'(plen_ff);
               rsp_in.step_dir    = 2'd0;
               rsp_in.last        = 1'b0;
               rsp_in.error       = 1'b0;
               case (req_data.action)
                  gmd_pkg::ACT_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (load_pos_ff >= cells_now) begin
                        rsp_in.error = 1'b1;
                     end else begin
                        wall_we     = 1'b1;
                        load_pos_in = load_pos_ff + CW'(1);
                        if (req_data.cell_kind == gmd_pkg::KIND_START) begin
                           start_in    = load_pos_ff;
                           start_ok_in = 1'b1;
                        end
                        if (req_data.cell_kind == gmd_pkg::KIND_END) begin
                           end_in    = load_pos_ff;
                           end_ok_in = 1'b1;
                        end
                     end
                  end
                  gmd_pkg::ACT_SEARCH: begin
                     rows_s_in  = rows_eff;
                     cols_s_in  = cols_eff;
                     cells_s_in = cells_now;
                     found_in   = 1'b0;
                     plen_in    = '0;
                     rpos_in    = '0;
                     top_in     = '0;
                     clr_in     = '0;
                     cr_in      = '0;
                     cc_in      = '0;
                     state_in   = S_CLEAR;
                  end
                  gmd_pkg::ACT_READ: begin
                     if (found_ff && (rpos_ff < plen_ff)) begin
                        state_in = S_PATH;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in.error = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     load_pos_in  = '0;
                     start_ok_in  = 1'b0;
                     end_ok_in    = 1'b0;
                  end
               endcase
            end
         end

         // sweep visited map; row/col counters also locate the start cell
         S_CLEAR: begin
            vis_we = 1'b1;
            if (clr_ff == start_ff) begin
               sr_in = cr_ff;
               sc_in = cc_ff;
            end
            if (int'(cc_ff) + 1 == int'(cols_s_ff)) begin
               cc_in = '0;
               cr_in = cr_ff + RIW'(1);
            end else begin
               cc_in = cc_ff + CIW'(1);
            end
            clr_in = clr_ff + CW'(1);
            if (clr_ff + CW'(1) == cells_s_ff) begin
               state_in = S_INIT;
            end
         end

         S_INIT: begin
            if (!start_ok_ff || !end_ok_ff || (start_ff >= cells_s_ff) ||
                (end_ff >= cells_s_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = S_IDLE;
            end else if (start_ff == end_ff) begin
               found_in     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.found = 1'b1;
               state_in     = S_IDLE;
            end else begin
               vis_we   = 1'b1;
               vis_wa   = start_ff[AW-1:0];
               vis_wd   = 1'b1;
               stk_we   = 1'b1;
               stk_wa   = '0;
               stk_wd   = {start_ff[AW-1:0], sr_ff, sc_ff};
               dir_we   = 1'b1;
               dir_wa   = '0;
               dir_wd   = gmd_pkg::DIR_RIGHT;
               top_in   = CW'(1);
               state_in = S_READ;
            end
         end

         S_READ: begin
            if (top_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = S_IDLE;
            end else begin
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            if (dir_rd >= gmd_pkg::DIR_DONE) begin
               top_in   = top_m1;
               state_in = S_READ;
            end else begin
               dir_we   = 1'b1;
               dir_wa   = top_m1[AW-1:0];
               dir_wd   = dir_rd + DW'(1);
               nr_in    = cur_r;
               nc_in    = cur_c;
               nb_in    = cur_cell;
               state_in = S_READ;
               case (dir_rd)
                  gmd_pkg::DIR_RIGHT: begin
                     nb_in = cur_cell + AW'(1);
                     nc_in = cur_c + CIW'(1);
                     if (int'(cur_c) + 1 < int'(cols_s_ff)) state_in = S_CHECK;
                  end
                  gmd_pkg::DIR_LEFT: begin
                     nb_in = cur_cell - AW'(1);
                     nc_in = cur_c - CIW'(1);
                     if (cur_c != '0) state_in = S_CHECK;
                  end
                  gmd_pkg::DIR_DOWN: begin
                     nb_in = cur_cell + AW'(cols_s_ff);
                     nr_in = cur_r + RIW'(1);
                     if (int'(cur_r) + 1 < int'(rows_s_ff)) state_in = S_CHECK;
                  end
                  default: begin
                     nb_in = cur_cell - AW'(cols_s_ff);
                     nr_in = cur_r - RIW'(1);
                     if (cur_r != '0) state_in = S_CHECK;
                  end
               endcase
            end
         end

         // wall and visited bits of the neighbor are on the read ports now
         S_CHECK: begin
            state_in = S_READ;
            if (!wall_rd && !vis_rd) begin
               if (nb_ff == end_ff[AW-1:0]) begin
                  found_in           = 1'b1;
                  plen_in            = top_ff;
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.found       = 1'b1;
                  rsp_in.path_length = 12'(top_ff);
                  state_in           = S_IDLE;
               end else begin
                  vis_we = 1'b1;
                  vis_wa = nb_ff;
                  vis_wd = 1'b1;
                  if (top_ff < CW'(CELLS)) begin
                     stk_we = 1'b1;
                     dir_we = 1'b1;
                     top_in = top_ff + CW'(1);
                  end
               end
            end
         end

         // path move = stored next-try code minus one
         S_PATH: begin
            rsp_valid_in       = 1'b1;
            rsp_in.found       = found_ff;
            rsp_in.path_length = 12'(plen_ff);
            rsp_in.step_dir    = 2'(dir_rd - DW'(1));
            rsp_in.last        = (rpos_ff + CW'(1) == plen_ff);
            rsp_in.error       = 1'b0;
            rpos_in            = rpos_ff + CW'(1);
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_cfg_ff  <= 7'd64;
         cols_cfg_ff  <= 7'd64;
         load_pos_ff  <= '0;
         start_ok_ff  <= 1'b0;
         end_ok_ff    <= 1'b0;
         found_ff     <= 1'b0;
         plen_ff      <= '0;
         rpos_ff      <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         load_pos_ff  <= load_pos_in;
         start_ok_ff  <= start_ok_in;
         end_ok_ff    <= end_ok_in;
         found_ff     <= found_in;
         plen_ff      <= plen_in;
         rpos_ff      <= rpos_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      end_ff     <= end_in;
      clr_ff     <= clr_in;
      cr_ff      <= cr_in;
      cc_ff      <= cc_in;
      sr_ff      <= sr_in;
      sc_ff      <= sc_in;
      rows_s_ff  <= rows_s_in;
      cols_s_ff  <= cols_s_in;
      cells_s_ff <= cells_s_in;
      nb_ff      <= nb_in;
      nr_ff      <= nr_in;
      nc_ff      <= nc_in;
      rsp_ff     <= rsp_in;
   end

   gmd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
      .clock   (clock),
      .wr_en   (wall_we),
      .wr_addr (wall_wa),
      .wr_data (wall_wd),
      .rd_addr (nb_in),
      .rd_data (wall_rd)
   );

   gmd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_wa),
      .wr_data (vis_wd),
      .rd_addr (nb_in),
      .rd_data (vis_rd)
   );

   gmd_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   // next-try code per stack level; after a hit it holds the path
   gmd_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dir (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_wa),
      .wr_data (dir_wd),
      .rd_addr (dir_ra),
      .rd_data (dir_rd)
   );

   // ---------------------------------------------------------------- checks
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= CW'(CELLS))
      else $error("stack top beyond cell count");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while command still in progress");

   a_no_path_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.path_length == 12'd0))
      else $error("path length without found");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.error && rsp_data.last))
      else $error("error and last together");

endmodule
